### rtl/buzzer_note_tone_generator_defines.svh
// Assertion macros used by the checker file, bnt_chk.sv.
`ifndef BUZZER_NOTE_TONE_GENERATOR_DEFINES_SVH
`define BUZZER_NOTE_TONE_GENERATOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define BNT_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("bnt assertion failed");

// next-cycle implication, held off during reset
`define BNT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("bnt assertion failed");

`endif

### rtl/bnt_pkg.sv
// Types and constants for the buzzer note tone generator.
package bnt_pkg;

    localparam logic       OP_START    = 1'b0;
    localparam logic       OP_TICK     = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_ZERO_DIV = 2'd2;

    localparam logic [15:0] WHOLE_NOTE_RESET = 16'd3000;
    localparam logic [20:0] CYCLES_MAX       = 21'h1FFFFF;
    localparam logic [31:0] US_PER_S         = 32'd1000000;
    localparam logic [15:0] MS_PER_S         = 16'd1000;
    localparam logic [15:0] GAP_DIVISOR      = 16'd10;

    typedef struct packed {
        logic              op;
        logic [14:0]       frequency_hz;
        logic signed [7:0] note_divider;
    } item_t;

    typedef struct packed {
        logic       pin_level;
        logic       busy_res;
        logic       note_done;
        logic [1:0] status;
    } result_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_REST,
        PH_GAP
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DUR,
        SQ_GAP,
        SQ_HALF,
        SQ_MUL,
        SQ_CYC
    } seq_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    function automatic logic [26:0] ms_to_us(input logic [16:0] ms);
        logic [26:0] prod;
        prod = {10'd0, ms} * 27'd1000;
        return prod;
    endfunction

endpackage

### rtl/bnt_div.sv
// Shared restoring divider, one quotient bit per cycle.
module bnt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bnt_pkg::div_req_t req,
    output bnt_pkg::div_rsp_t rsp
);
    import bnt_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] divisor_reg, divisor_next;
    logic [16:0] shifted;
    logic [16:0] trial;

    always_comb
    begin
        shifted      = {rem_reg, quo_reg[31]};
        trial        = shifted - {1'b0, divisor_reg};
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = trial[16] ? shifted[15:0] : trial[15:0];
            quo_next = {quo_reg[30:0], ~trial[16]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### rtl/buzzer_note_tone_generator.sv
// Top level of the buzzer note tone generator: sequencer, tone timing, output register.
//
//  channel  direction  handshake               word
//  item     in         item_valid/item_stall   item_t (op, frequency_hz, note_divider)
//  result   out        result_valid/result_stall  result_t (pin, busy, done, status)
//  cfg      in         cfg_valid/cfg_ready     whole_note_ms, 16 bits
//
// A tick or a rejected start is answered from SQ_IDLE; ticks may follow back to back while the result is not stalled.
// An accepted start runs 32-step passes through the shared divider for duration and
// gap, and for a nonzero frequency also for half period, one multiply and cycle count.
// Reset leaves the tone idle and whole_note_ms at 3000; cfg_ready is always high.
// A stalled result holds the result register and stalls the item channel.
module buzzer_note_tone_generator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  bnt_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output bnt_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [15:0]      cfg_data
);
    import bnt_pkg::*;

    seq_t        seq_reg, seq_next;
    phase_t      phase_reg, phase_next;
    logic [18:0] half_period_reg, half_period_next;
    logic [18:0] half_count_reg, half_count_next;
    logic [20:0] cycles_left_reg, cycles_left_next;
    logic [26:0] wait_count_reg, wait_count_next;
    logic [13:0] gap_ms_reg, gap_ms_next;
    logic [15:0] whole_note_reg, whole_note_next;
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, result_next;
    logic [14:0] freq_reg, freq_next;
    logic        dotted_reg, dotted_next;
    logic [16:0] dur_reg, dur_next;
    logic [31:0] prod_reg, prod_next;
    logic        accept;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    bnt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept     = (seq_reg == SQ_IDLE) && (!result_valid_reg || !result_stall);
    assign item_stall = !accept;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        logic [7:0]  div_bits;
        logic [7:0]  mag;
        logic [17:0] dur3;
        logic [16:0] dur_n;
        logic [20:0] cyc;
        logic [1:0]  status_val;
        logic        done_flag;
        logic        load;

        div_bits   = item.note_divider;
        mag        = div_bits[7] ? (~div_bits + 8'd1) : div_bits;
        dur3       = {1'b0, div_rsp.quotient[15:0], 1'b0} + {2'b00, div_rsp.quotient[15:0]};
        dur_n      = dotted_reg ? dur3[17:1] : {1'b0, div_rsp.quotient[15:0]};
        cyc        = (div_rsp.quotient > {11'd0, CYCLES_MAX}) ? CYCLES_MAX
                                                               : div_rsp.quotient[20:0];
        status_val = ST_OK;
        done_flag  = 1'b0;
        load       = 1'b0;

        seq_next          = seq_reg;
        phase_next        = phase_reg;
        half_period_next  = half_period_reg;
        half_count_next   = half_count_reg;
        cycles_left_next  = cycles_left_reg;
        wait_count_next   = wait_count_reg;
        gap_ms_next       = gap_ms_reg;
        whole_note_next   = whole_note_reg;
        freq_next         = freq_reg;
        dotted_next       = dotted_reg;
        dur_next          = dur_reg;
        prod_next         = prod_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        div_req.start     = 1'b0;
        div_req.dividend  = '0;
        div_req.divisor   = '0;

        if (cfg_valid)
        begin
            whole_note_next = cfg_data;
        end

        case (seq_reg)
            SQ_IDLE:
            begin
                if (item_valid && accept)
                begin
                    load = 1'b1;
                    if (item.op == OP_TICK)
                    begin
                        case (phase_reg)
                            PH_HIGH:
                            begin
                                if (half_count_reg > 19'd1)
                                begin
                                    half_count_next = half_count_reg - 19'd1;
                                end
                                else
                                begin
                                    phase_next      = PH_LOW;
                                    half_count_next = half_period_reg;
                                end
                            end
                            PH_LOW:
                            begin
                                if (half_count_reg > 19'd1)
                                begin
                                    half_count_next = half_count_reg - 19'd1;
                                end
                                else if (cycles_left_reg > 21'd1)
                                begin
                                    cycles_left_next = cycles_left_reg - 21'd1;
                                    phase_next       = PH_HIGH;
                                    half_count_next  = half_period_reg;
                                end
                                else
                                begin
                                    cycles_left_next = '0;
                                    half_count_next  = '0;
                                    wait_count_next  = ms_to_us({3'd0, gap_ms_reg});
                                    phase_next       = PH_GAP;
                                end
                            end
                            PH_REST:
                            begin
                                if (wait_count_reg > 27'd1)
                                begin
                                    wait_count_next = wait_count_reg - 27'd1;
                                end
                                else
                                begin
                                    wait_count_next = ms_to_us({3'd0, gap_ms_reg});
                                    phase_next      = PH_GAP;
                                end
                            end
                            PH_GAP:
                            begin
                                if (wait_count_reg > 27'd1)
                                begin
                                    wait_count_next = wait_count_reg - 27'd1;
                                end
                                else
                                begin
                                    wait_count_next = '0;
                                    phase_next      = PH_IDLE;
                                    done_flag       = 1'b1;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                    else if (phase_reg != PH_IDLE)
                    begin
                        status_val = ST_BUSY;
                    end
                    else if (div_bits == 8'd0)
                    begin
                        status_val = ST_ZERO_DIV;
                    end
                    else
                    begin
                        load             = 1'b0;
                        freq_next        = item.frequency_hz;
                        dotted_next      = div_bits[7];
                        div_req.start    = 1'b1;
                        div_req.dividend = {16'd0, whole_note_reg};
                        div_req.divisor  = {8'd0, mag};
                        seq_next         = SQ_DUR;
                    end
                end
            end
            SQ_DUR:
            begin
                if (div_rsp.done)
                begin
                    dur_next         = dur_n;
                    div_req.start    = 1'b1;
                    div_req.dividend = {15'd0, dur_n};
                    div_req.divisor  = GAP_DIVISOR;
                    seq_next         = SQ_GAP;
                end
            end
            SQ_GAP:
            begin
                if (div_rsp.done)
                begin
                    gap_ms_next = div_rsp.quotient[13:0];
                    if (freq_reg == 15'd0)
                    begin
                        if (dur_reg == 17'd0)
                        begin
                            wait_count_next = ms_to_us({3'd0, div_rsp.quotient[13:0]});
                            phase_next      = PH_GAP;
                        end
                        else
                        begin
                            wait_count_next = ms_to_us(dur_reg);
                            phase_next      = PH_REST;
                        end
                        load     = 1'b1;
                        seq_next = SQ_IDLE;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = US_PER_S;
                        div_req.divisor  = {freq_reg, 1'b0};
                        seq_next         = SQ_HALF;
                    end
                end
            end
            SQ_HALF:
            begin
                if (div_rsp.done)
                begin
                    half_period_next = div_rsp.quotient[18:0];
                    prod_next        = {17'd0, freq_reg} * {15'd0, dur_reg};
                    seq_next         = SQ_MUL;
                end
            end
            SQ_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = MS_PER_S;
                seq_next         = SQ_CYC;
            end
            SQ_CYC:
            begin
                if (div_rsp.done)
                begin
                    cycles_left_next = cyc;
                    if (cyc == 21'd0)
                    begin
                        wait_count_next = ms_to_us({3'd0, gap_ms_reg});
                        phase_next      = PH_GAP;
                    end
                    else
                    begin
                        half_count_next = half_period_reg;
                        phase_next      = PH_HIGH;
                    end
                    load     = 1'b1;
                    seq_next = SQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase

        if (load)
        begin
            result_valid_next     = 1'b1;
            result_next.pin_level = (phase_next == PH_HIGH);
            result_next.busy_res  = (phase_next != PH_IDLE);
            result_next.note_done = done_flag;
            result_next.status    = status_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg          <= SQ_IDLE;
            phase_reg        <= PH_IDLE;
            half_period_reg  <= '0;
            half_count_reg   <= '0;
            cycles_left_reg  <= '0;
            wait_count_reg   <= '0;
            gap_ms_reg       <= '0;
            whole_note_reg   <= WHOLE_NOTE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg          <= seq_next;
            phase_reg        <= phase_next;
            half_period_reg  <= half_period_next;
            half_count_reg   <= half_count_next;
            cycles_left_reg  <= cycles_left_next;
            wait_count_reg   <= wait_count_next;
            gap_ms_reg       <= gap_ms_next;
            whole_note_reg   <= whole_note_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        freq_reg   <= freq_next;
        dotted_reg <= dotted_next;
        dur_reg    <= dur_next;
        prod_reg   <= prod_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/bnt_chk.sv
// Port-level checker for the buzzer note tone generator, with its bind.
`include "buzzer_note_tone_generator_defines.svh"

module bnt_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input bnt_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input bnt_pkg::result_t result,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [15:0]      cfg_data
);
    import bnt_pkg::*;

    // held word stays put
    `BNT_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    // full, stalled result register blocks new items
    `BNT_ASSERT_IMPLY(a_back, clk, rst_n, result_valid && result_stall, item_stall)
    // pin high only while busy
    `BNT_ASSERT_IMPLY(a_pin, clk, rst_n, result_valid && result.pin_level, result.busy_res)
    // end of gap: idle, status ok
    `BNT_ASSERT_IMPLY(a_done, clk, rst_n, result_valid && result.note_done, !result.busy_res && (result.status == ST_OK))

endmodule

bind buzzer_note_tone_generator bnt_chk u_bnt_chk (.*);
